// ===== sv/gd_pkg.sv =====
// Shared types, codes and constants for the multi-button gesture detector.
package gd_pkg;

    localparam int NUM_BUTTONS_DEF = 8;
    localparam int TICK_WIDTH_DEF  = 16;
    localparam int MAX_RESULTS     = 8;
    localparam int THR_W           = 16;
    localparam int CFG_IDX_W       = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSED_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TICKS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS    = 3'd4;

    // reset values of the thresholds
    localparam logic [THR_W-1:0] CLICK_TICKS_RST = 16'd7;
    localparam logic [THR_W-1:0] SHORT_TICKS_RST = 16'd12;
    localparam logic [THR_W-1:0] LONG_TICKS_RST  = 16'd27;
    localparam logic [THR_W-1:0] HOLD_TICKS_RST  = 16'd32;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PRESSED  = 3'd1,
        PH_RELEASED = 3'd2,
        PH_WAIT2    = 3'd3,
        PH_SHORT    = 3'd4,
        PH_LONG     = 3'd5,
        PH_HOLD     = 3'd6
    } phase_t;

    typedef enum logic [3:0] {
        EV_DOWN     = 4'd0,
        EV_CLICK    = 4'd1,
        EV_DOUBLE   = 4'd2,
        EV_SHORT    = 4'd3,
        EV_SHORT_UP = 4'd4,
        EV_LONG     = 4'd5,
        EV_LONG_UP  = 4'd6,
        EV_HOLD     = 4'd7,
        EV_HOLD_UP  = 4'd8
    } ev_t;

    typedef struct packed {
        logic [THR_W-1:0] click_ticks;
        logic [THR_W-1:0] short_ticks;
        logic [THR_W-1:0] long_ticks;
        logic [THR_W-1:0] hold_ticks;
    } thr_t;

    typedef struct packed {
        logic fire;
        ev_t  code;
    } lane_ev_t;

endpackage

// ===== sv/gd_lane.sv =====
// One button lane: phase machine, saturating tick counter and click counter.
module gd_lane #(
    parameter int TICK_WIDTH = gd_pkg::TICK_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic            now,
    input  logic            rise,
    input  gd_pkg::thr_t    thr,
    output gd_pkg::lane_ev_t ev
);

    localparam int CMP_W = (TICK_WIDTH > gd_pkg::THR_W) ? TICK_WIDTH : gd_pkg::THR_W;
    localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

    gd_pkg::phase_t          phase_reg, phase_next;
    logic [TICK_WIDTH-1:0]   tick_reg, tick_next;
    logic [1:0]              cc_reg, cc_next;
    logic [TICK_WIDTH-1:0]   t;
    logic [1:0]              cc_inc;
    logic [CMP_W-1:0]        t_ext;
    logic                    lt_click, lt_short, lt_long, lt_hold;

    // counter runs while not idle, saturating
    always_comb
    begin
        t = tick_reg;
        if (phase_reg != gd_pkg::PH_IDLE && tick_reg != TICK_MAX)
        begin
            t = tick_reg + 1'b1;
        end
    end

    assign t_ext    = CMP_W'(t);
    assign lt_click = t_ext < CMP_W'(thr.click_ticks);
    assign lt_short = t_ext < CMP_W'(thr.short_ticks);
    assign lt_long  = t_ext < CMP_W'(thr.long_ticks);
    assign lt_hold  = t_ext < CMP_W'(thr.hold_ticks);
    assign cc_inc   = cc_reg + 2'd1;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = t;
        cc_next    = cc_reg;
        unique case (phase_reg)
            gd_pkg::PH_IDLE:
            begin
                if (rise)
                begin
                    tick_next  = '0;
                    cc_next    = '0;
                    phase_next = gd_pkg::PH_PRESSED;
                end
            end
            gd_pkg::PH_PRESSED:
            begin
                if (!now)
                    phase_next = gd_pkg::PH_RELEASED;
                else if (!lt_short && lt_long)
                    phase_next = gd_pkg::PH_SHORT;
            end
            gd_pkg::PH_RELEASED:
            begin
                if (lt_click && cc_inc == 2'd1)
                begin
                    cc_next    = cc_inc;
                    phase_next = gd_pkg::PH_WAIT2;
                end
                else
                begin
                    // every other window ends the gesture
                    cc_next    = '0;
                    phase_next = gd_pkg::PH_IDLE;
                end
            end
            gd_pkg::PH_WAIT2:
            begin
                if (rise)
                begin
                    cc_next    = cc_inc;
                    phase_next = gd_pkg::PH_RELEASED;
                    tick_next  = (t == '0) ? '0 : t - 1'b1;
                end
                else if (!lt_click)
                begin
                    phase_next = gd_pkg::PH_RELEASED;
                end
            end
            gd_pkg::PH_SHORT:
            begin
                if (!now)
                    phase_next = gd_pkg::PH_RELEASED;
                else if (!lt_long && lt_hold)
                    phase_next = gd_pkg::PH_LONG;
            end
            gd_pkg::PH_LONG:
            begin
                if (!now)
                    phase_next = gd_pkg::PH_RELEASED;
                else if (!lt_hold)
                    phase_next = gd_pkg::PH_HOLD;
            end
            gd_pkg::PH_HOLD:
            begin
                if (!now)
                    phase_next = gd_pkg::PH_RELEASED;
            end
            default:
            begin
                phase_next = gd_pkg::PH_IDLE;
            end
        endcase
    end

    // event output
    always_comb
    begin
        ev.fire = 1'b0;
        ev.code = gd_pkg::EV_DOWN;
        unique case (phase_reg)
            gd_pkg::PH_IDLE:
            begin
                ev.fire = rise;
            end
            gd_pkg::PH_PRESSED:
            begin
                ev.fire = now && !lt_short && lt_long;
                ev.code = gd_pkg::EV_SHORT;
            end
            gd_pkg::PH_RELEASED:
            begin
                ev.fire = 1'b1;
                if (lt_click)
                begin
                    ev.fire = (cc_inc != 2'd1);
                    ev.code = gd_pkg::EV_DOUBLE;
                end
                else if (lt_short)
                    ev.code = gd_pkg::EV_CLICK;
                else if (lt_long)
                    ev.code = gd_pkg::EV_SHORT_UP;
                else if (lt_hold)
                    ev.code = gd_pkg::EV_LONG_UP;
                else
                    ev.code = gd_pkg::EV_HOLD_UP;
            end
            gd_pkg::PH_SHORT:
            begin
                ev.fire = now && !lt_long && lt_hold;
                ev.code = gd_pkg::EV_LONG;
            end
            gd_pkg::PH_LONG:
            begin
                ev.fire = now && !lt_hold;
                ev.code = gd_pkg::EV_HOLD;
            end
            default:
            begin
                ev.fire = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= gd_pkg::PH_IDLE;
            tick_reg  <= '0;
            cc_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            cc_reg    <= cc_next;
        end
    end

    // click counter never reaches three
    a_cc_range: assert property (@(posedge clk) disable iff (!rst_n)
        cc_reg != 2'd3)
        else $error("click counter out of range");

    // idle lane without a new press keeps its counter
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == gd_pkg::PH_IDLE && !rise) |=> $stable(tick_reg))
        else $error("idle lane counter moved");

endmodule

// ===== sv/gd_merge.sv =====
// Merge stage: latches lane events of one tick and sends them out in button order.
module gd_merge #(
    parameter int NUM_BUTTONS = gd_pkg::NUM_BUTTONS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                capture,
    input  gd_pkg::lane_ev_t [NUM_BUTTONS-1:0]  ev_in,
    output logic                                in_ready,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2:0]                          out_index,
    output gd_pkg::ev_t                         out_code,
    output logic                                out_last
);

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int CNT_W = $clog2(NUM_BUTTONS + 1);

    logic [NUM_BUTTONS-1:0] pend_reg, pend_next, pend_after, low_bit, keep;
    gd_pkg::ev_t            code_reg [NUM_BUTTONS];
    logic                   out_valid_reg, out_valid_next;
    logic [2:0]             out_index_reg;
    gd_pkg::ev_t            out_code_reg;
    logic                   out_last_reg;
    logic                   take, pop;
    logic [IDX_W-1:0]       idx;
    logic [CNT_W-1:0]       cnt;

    // keep only the first MAX_RESULTS events of a tick
    always_comb
    begin
        cnt  = '0;
        keep = '0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            keep[i] = ev_in[i].fire && (32'(cnt) < gd_pkg::MAX_RESULTS);
            cnt     = cnt + CNT_W'(ev_in[i].fire);
        end
    end

    // lowest pending button goes first
    always_comb
    begin
        idx = '0;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
                idx = IDX_W'(i);
        end
    end

    assign low_bit    = pend_reg & (~pend_reg + 1'b1);
    assign take       = !out_valid_reg || out_ready;
    assign pop        = take && (pend_reg != '0);
    assign pend_after = pop ? (pend_reg & ~low_bit) : pend_reg;
    assign in_ready   = (pend_after == '0);
    assign pend_next  = capture ? keep : pend_after;

    always_comb
    begin
        if (pop)
            out_valid_next = 1'b1;
        else if (take)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                code_reg[i] <= ev_in[i].code;
            end
        end
        if (pop)
        begin
            out_index_reg <= 3'(idx);
            out_code_reg  <= code_reg[idx];
            out_last_reg  <= (pend_after == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_code  = out_code_reg;
    assign out_last  = out_last_reg;

    a_pend_limit: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(pend_reg) <= gd_pkg::MAX_RESULTS)
        else $error("too many pending events");

    // a non-final event always has a successor waiting
    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (pend_reg != '0))
        else $error("event without last flag but nothing pending");

endmodule

// ===== sv/multi_button_gesture_detector.sv =====
// Top level of the multi-button gesture detector: config, lanes and merge.
//
// Each slave transaction is one scan tick carrying the raw level of every
// button. The raw levels are turned into a pressed vector by pressed_level,
// new presses are found against the previous tick, and one lane per button
// runs the gesture machine (down, click, double, short, long, hold and their
// releases) against the four tick thresholds. Every event of the tick comes
// out as one master transaction, lowest button first, with tlast on the
// final event of the tick; at most eight events per tick, extra ones from
// higher buttons are dropped while their lanes still advance. A tick that
// fires no event leaves the next tick free to enter; one that fires events
// holds the single output channel until all are sent, and the next tick is
// accepted in the cycle its last event moves into the output register.
// The user must write configuration only while the block is idle; it is not enforced.
module multi_button_gesture_detector #(
    parameter int NUM_BUTTONS = gd_pkg::NUM_BUTTONS_DEF,
    parameter int TICK_WIDTH  = gd_pkg::TICK_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // scan tick in
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] raw_levels
    // events out
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,   // [2:0] button_index, [6:3] event_code
    output logic                          m_axis_tlast,   // last_event
    // register writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gd_pkg::THR_W-1:0]      cfg_data
);

    logic                    pressed_level_reg;
    gd_pkg::thr_t            thr_reg;
    logic [NUM_BUTTONS-1:0]  held_reg;
    logic [NUM_BUTTONS-1:0]  raw_ext, pressed, rise;
    logic                    accept;
    logic                    merge_ready;
    logic [2:0]              out_index;
    gd_pkg::ev_t             out_code;
    gd_pkg::lane_ev_t [NUM_BUTTONS-1:0] lane_ev;

    // register writes are always taken; indexes past the list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_level_reg   <= 1'b0;
            thr_reg.click_ticks <= gd_pkg::CLICK_TICKS_RST;
            thr_reg.short_ticks <= gd_pkg::SHORT_TICKS_RST;
            thr_reg.long_ticks  <= gd_pkg::LONG_TICKS_RST;
            thr_reg.hold_ticks  <= gd_pkg::HOLD_TICKS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                gd_pkg::CFG_PRESSED_LEVEL: pressed_level_reg   <= cfg_data[0];
                gd_pkg::CFG_CLICK_TICKS:   thr_reg.click_ticks <= cfg_data;
                gd_pkg::CFG_SHORT_TICKS:   thr_reg.short_ticks <= cfg_data;
                gd_pkg::CFG_LONG_TICKS:    thr_reg.long_ticks  <= cfg_data;
                gd_pkg::CFG_HOLD_TICKS:    thr_reg.hold_ticks  <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // polarity and press edges; buttons past the 8-bit field read raw zero
    assign raw_ext = NUM_BUTTONS'(s_axis_tdata);
    assign pressed = pressed_level_reg ? raw_ext : ~raw_ext;
    assign rise    = pressed & ~held_reg;

    assign s_axis_tready = merge_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= '0;
        else if (accept)
            held_reg <= pressed;
    end

    // one lane per button, all stepped by the same tick
    for (genvar b = 0; b < NUM_BUTTONS; b++)
    begin : g_lane
        gd_lane #(
            .TICK_WIDTH (TICK_WIDTH)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .step  (accept),
            .now   (pressed[b]),
            .rise  (rise[b]),
            .thr   (thr_reg),
            .ev    (lane_ev[b])
        );
    end

    gd_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .capture   (accept),
        .ev_in     (lane_ev),
        .in_ready  (merge_ready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_index (out_index),
        .out_code  (out_code),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_code, out_index};

    // pressed vector only moves on an accepted tick
    a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(held_reg))
        else $error("pressed vector changed without a tick");

endmodule
